// File: design/wrm_pkg.sv
// Package for the wavetable ring modulator: sizes, sequencer states and
// the elaboration-time cosine table builder. No dependencies.
package wrm_pkg;

  // Table length, a power of two between 64 and 8192.
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned TableBits    = $clog2(TableEntries);
  localparam int unsigned RomAddrW     = TableBits + 1;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned PhaseW       = TableBits + FracBits;

  localparam int unsigned SampleW = 24;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned IncW    = 25;
  localparam int unsigned ModW    = 32;
  localparam int unsigned ProdW   = SampleW + ModW;

  localparam logic [IncW-1:0] IncReset = IncW'(139810);

  // Register byte addresses on the configuration port.
  localparam int unsigned   PaddrW      = 3;
  localparam logic [PaddrW-1:0] AddrPhaseInc = PaddrW'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_HI,
    ST_LERP,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef logic signed [CoefW-1:0] cos_table_t [TableEntries+1];

  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;
  localparam logic [63:0] OneQ30   = 64'd1 << 30;

  // Taylor term divisor (2k-1)*2k for term k.
  function automatic logic [63:0] term_div(input logic [63:0] num, input int k);
    logic [63:0] q;
    case (k)
      1:       q = num / 2;
      2:       q = num / 12;
      3:       q = num / 30;
      4:       q = num / 56;
      5:       q = num / 90;
      6:       q = num / 132;
      7:       q = num / 182;
      8:       q = num / 240;
      9:       q = num / 306;
      10:      q = num / 380;
      default: q = num;
    endcase
    return q;
  endfunction

  // Cosine of 2*pi*i/TableEntries, rounded to Q1.15 and saturated.
  function automatic logic signed [CoefW-1:0] cos_entry(input logic [63:0] i);
    logic [63:0]        t;
    logic               neg;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        c15;
    logic [63:0]        turn_half;
    logic [63:0]        turn_quarter;
    turn_half    = 64'd1 << 31;
    turn_quarter = 64'd1 << 30;
    t   = (i << 32) / TableEntries;
    neg = 1'b0;
    if (t > turn_half) begin
      t = (64'd1 << 32) - t;
    end
    if (t > turn_quarter) begin
      t   = turn_half - t;
      neg = 1'b1;
    end
    x    = (t * TwoPiQ30) >> 32;
    x2   = (x * x) >> 30;
    term = OneQ30;
    sum  = $signed(OneQ30);
    for (int k = 1; k <= 10; k++) begin
      term = term_div((term * x2) >> 30, k);
      if ((k % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    c15 = ($unsigned(sum) + (64'd1 << 14)) >> 15;
    if (c15 > 64'd32768) begin
      c15 = 64'd32768;
    end
    if (neg) begin
      return CoefW'(-$signed(c15));
    end
    if (c15 > 64'd32767) begin
      return CoefW'(32767);
    end
    return CoefW'(c15);
  endfunction

  function automatic cos_table_t build_cos_table();
    cos_table_t tbl;
    for (int i = 0; i <= int'(TableEntries); i++) begin
      tbl[i] = cos_entry(64'(i));
    end
    return tbl;
  endfunction

endpackage

// File: design/wrm_if.sv
// Handshake channels of the wavetable ring modulator: sample in, sample out.
// Depends on wrm_pkg for field widths.
interface wrm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wrm_pkg::SampleW-1:0]   in_sample;
  logic                                 end_of_frame;

  modport source (output valid, output in_sample, output end_of_frame, input ready);
  modport sink   (input valid, input in_sample, input end_of_frame, output ready);
endinterface

interface wrm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wrm_pkg::SampleW-1:0]   out_sample;
  logic                                 out_end_of_frame;

  modport source (output valid, output out_sample, output out_end_of_frame, input ready);
  modport sink   (input valid, input out_sample, input out_end_of_frame, output ready);
endinterface

// File: design/wrm_cos_rom.sv
// Cosine wavetable ROM, TableEntries+1 entries of Q1.15, registered read.
// Contents are built at elaboration by wrm_pkg::build_cos_table.
module wrm_cos_rom (
  input  logic                                 clk_i,
  input  logic [wrm_pkg::RomAddrW-1:0]         addr_i,
  output logic signed [wrm_pkg::CoefW-1:0]     data_o
);

  localparam wrm_pkg::cos_table_t Rom = wrm_pkg::build_cos_table();

  logic signed [wrm_pkg::CoefW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= Rom[addr_i];
  end

  assign data_o = data_q;

endmodule

// File: design/wavetable_ring_modulator.sv
// Top level of the wavetable ring modulator.
// Depends on wrm_pkg, wrm_in_if / wrm_out_if and wrm_cos_rom.
//
// Usage:
//   in_i carries one Q1.23 sample per item plus an end-of-frame flag marking
//   the last channel of a frame. out_o returns one item per input: the
//   sample times an interpolated cosine, rounded half up and saturated to
//   24 bits, with the flag copied. All channels of a frame see the same
//   modulating value; the phase advances by phase_increment after an item
//   whose flag is set, wrapping modulo the table length.
//   The APB port holds phase_increment at byte address 0 (reset 139810).
// Sequence:
//   An accepted item reaches the output register after two ROM reads
//   through the single read port, then one shared 24x32 multiplier used
//   twice (interpolation, then modulation). in_i.ready is high only when the
//   sequencer is idle, so an item is taken only after the last result has entered the output register.
// Reset and stall:
//   Reset clears the phase and the output valid. When the receiver stalls,
//   the result waits in the output register; the next item is still taken
//   and its result is held back until the register frees up.
module wavetable_ring_modulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wrm_in_if.sink                        in_i,
  wrm_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrm_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned SW = wrm_pkg::SampleW;
  localparam int unsigned CW = wrm_pkg::CoefW;
  localparam int unsigned MW = wrm_pkg::ModW;
  localparam int unsigned PW = wrm_pkg::ProdW;
  localparam int unsigned FB = wrm_pkg::FracBits;

  wrm_pkg::state_e state_q, state_d;

  logic [wrm_pkg::IncW-1:0]       inc_q;
  logic [wrm_pkg::PhaseW-1:0]     phase_q, phase_d;
  logic signed [SW-1:0]           sample_q;
  logic                           eof_q;
  logic signed [CW-1:0]           lo_q;
  logic signed [MW-1:0]           mod_q;
  logic signed [PW-1:0]           prod_q;
  logic                           out_valid_q, out_valid_d;
  logic signed [SW-1:0]           out_sample_q;
  logic                           out_eof_q;

  // Sequencer controls
  logic                           accept;
  logic                           load_lo;
  logic                           load_mod;
  logic                           load_prod;
  logic                           load_out;
  logic                           sel_lerp;
  logic                           sel_hi_addr;

  logic [wrm_pkg::RomAddrW-1:0]   rom_addr;
  logic signed [CW-1:0]           rom_data;

  logic signed [SW-1:0]           mul_a;
  logic signed [MW-1:0]           mul_b;
  logic signed [PW-1:0]           mul_p;
  logic signed [CW:0]             diff;
  logic signed [FB+CW+1:0]        mod_sum;

  logic signed [PW:0]             rnd;
  logic signed [PW-31:0]          shifted;
  logic signed [SW-1:0]           sat;

  logic [wrm_pkg::TableBits-1:0]  pos;
  logic [FB-1:0]                  frac;

  assign pos  = phase_q[wrm_pkg::PhaseW-1:FB];
  assign frac = phase_q[FB-1:0];

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr == wrm_pkg::AddrPhaseInc) begin
      prdata = 32'(inc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q <= wrm_pkg::IncReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == wrm_pkg::AddrPhaseInc)) begin
      inc_q <= pwdata[wrm_pkg::IncW-1:0];
    end
  end

  // ---------------- sequencer ----------------
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      wrm_pkg::ST_IDLE:  if (in_i.valid) state_d = wrm_pkg::ST_RD_HI;
      wrm_pkg::ST_RD_HI: state_d = wrm_pkg::ST_LERP;
      wrm_pkg::ST_LERP:  state_d = wrm_pkg::ST_MUL;
      wrm_pkg::ST_MUL:   state_d = wrm_pkg::ST_DONE;
      wrm_pkg::ST_DONE:  if (!out_valid_q || out_o.ready) state_d = wrm_pkg::ST_IDLE;
      default:           state_d = wrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    load_lo     = 1'b0;
    load_mod    = 1'b0;
    load_prod   = 1'b0;
    load_out    = 1'b0;
    sel_lerp    = 1'b0;
    sel_hi_addr = 1'b0;
    case (state_q)
      wrm_pkg::ST_IDLE:  in_i.ready = 1'b1;
      wrm_pkg::ST_RD_HI: begin
        load_lo     = 1'b1;
        sel_hi_addr = 1'b1;
      end
      wrm_pkg::ST_LERP: begin
        sel_lerp = 1'b1;
        load_mod = 1'b1;
      end
      wrm_pkg::ST_MUL:   load_prod = 1'b1;
      wrm_pkg::ST_DONE:  load_out  = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- table read ----------------
  assign rom_addr = sel_hi_addr ? wrm_pkg::RomAddrW'({1'b0, pos} + 1'b1)
                                : wrm_pkg::RomAddrW'(pos);

  wrm_cos_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // ---------------- shared multiplier ----------------
  // Interpolate as lo*65536 + (hi - lo)*frac, then scale the sample.
  assign diff  = (CW+1)'(rom_data) - (CW+1)'(lo_q);
  assign mul_a = sel_lerp ? SW'(diff) : sample_q;
  assign mul_b = sel_lerp ? MW'($signed({1'b0, frac})) : mod_q;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign mod_sum = $signed({{2{lo_q[CW-1]}}, lo_q, {FB{1'b0}}})
                 + (FB+CW+2)'(mul_p);

  // Round half up, then saturate.
  assign rnd     = (PW+1)'(prod_q) + (PW+1)'(64'd1 << 30);
  assign shifted = rnd[PW:31];
  always_comb begin
    if (shifted[PW-31:SW-1] == '0 || shifted[PW-31:SW-1] == '1) begin
      sat = shifted[SW-1:0];
    end else if (shifted[PW-31]) begin
      sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_i.in_sample;
      eof_q    <= in_i.end_of_frame;
    end
    if (load_lo) begin
      lo_q <= rom_data;
    end
    if (load_mod) begin
      mod_q <= mod_sum[MW-1:0];
    end
    if (load_prod) begin
      prod_q <= mul_p;
    end
    if (load_out) begin
      out_sample_q <= sat;
      out_eof_q    <= eof_q;
    end
  end

  // ---------------- phase and output valid ----------------
  always_comb begin
    phase_d = phase_q;
    if (load_out && eof_q) begin
      phase_d = phase_q + wrm_pkg::PhaseW'(inc_q);
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.out_sample       = out_sample_q;
  assign out_o.out_end_of_frame = out_eof_q;

endmodule
